@@ hw/rtl/key_edge_subscription_notifier_defines.svh @@
// Assertion macros for the key edge subscription notifier.
`ifndef KEY_EDGE_SUBSCRIPTION_NOTIFIER_DEFINES_SVH
`define KEY_EDGE_SUBSCRIPTION_NOTIFIER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KESN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define KESN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/kesn_pkg.sv @@
// Types and constants shared by the key edge subscription notifier.
package kesn_pkg;

  localparam int KEY_W  = 3;
  localparam int ID_W   = 8;
  localparam int CODE_W = 5;
  localparam int MAX_KEYS = 8;

  localparam logic [CODE_W-1:0] CODE_RELEASE = 5'h08;
  localparam logic [CODE_W-1:0] CODE_CLEAR   = 5'h10;

  typedef struct packed {
    logic             op;
    logic [7:0]       levels;
    logic [ID_W-1:0]  requester;
    logic [KEY_W-1:0] key_index;
    logic             release_edge;
    logic             clear_request;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]   recipient;
    logic [CODE_W-1:0] event_code;
    logic              last;
  } out_t;

  // per-key control broadcast from the top level
  typedef struct packed {
    logic            sample_en;
    logic            lvl_old;
    logic            lvl_new;
    logic            req_en;
    logic            rel;
    logic            clr;
    logic [ID_W-1:0] who;
  } kesn_lane_ctl_t;

  // one pending notification
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   who;
    logic [CODE_W-1:0] code;
  } kesn_note_t;

endpackage

@@ hw/rtl/kesn_lane.sv @@
// One key lane: press and release slots, edge detect, pending notification.
module kesn_lane
  import kesn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] lane_id,
  input  kesn_lane_ctl_t   ctl,
  input  logic             req_sel,
  input  logic             grant,
  output kesn_note_t       note
);

  logic [ID_W-1:0]   press_r, press_nxt;
  logic [ID_W-1:0]   release_r, release_nxt;
  logic              pend_r, pend_nxt;
  logic [ID_W-1:0]   who_r, who_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              rise, fall;

  assign rise = ctl.lvl_new & ~ctl.lvl_old;
  assign fall = ctl.lvl_old & ~ctl.lvl_new;

  always_comb begin
    press_nxt   = press_r;
    release_nxt = release_r;
    pend_nxt    = pend_r;
    who_nxt     = who_r;
    code_nxt    = code_r;
    if (grant) begin
      pend_nxt = 1'b0;
    end
    if (ctl.sample_en) begin
      if (rise && press_r != '0) begin
        pend_nxt  = 1'b1;
        who_nxt   = press_r;
        code_nxt  = {2'b00, lane_id};
        press_nxt = '0;
      end else if (fall && release_r != '0) begin
        pend_nxt    = 1'b1;
        who_nxt     = release_r;
        code_nxt    = {2'b00, lane_id} | CODE_RELEASE;
        release_nxt = '0;
      end
    end
    if (ctl.req_en && req_sel) begin
      if (ctl.rel) begin
        release_nxt = ctl.clr ? '0 : ctl.who;
      end else begin
        press_nxt = ctl.clr ? '0 : ctl.who;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r   <= '0;
      release_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      press_r   <= press_nxt;
      release_r <= release_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    who_r  <= who_nxt;
    code_r <= code_nxt;
  end

  assign note.valid = pend_r;
  assign note.who   = who_r;
  assign note.code  = code_r;

endmodule

@@ hw/rtl/kesn_merge.sv @@
// Merge stage: picks the lowest pending lane or the clear echo into the output register.
module kesn_merge
  import kesn_pkg::*;
#(
  parameter int NUM_KEYS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kesn_note_t          pend [NUM_KEYS],
  input  kesn_note_t          echo_in,
  input  logic                out_ready,
  output logic                out_valid,
  output out_t                out_data,
  output logic [NUM_KEYS-1:0] grant,
  output logic                busy
);

  logic              echo_v_r, echo_v_nxt;
  logic [ID_W-1:0]   echo_who_r, echo_who_nxt;
  logic [CODE_W-1:0] echo_code_r, echo_code_nxt;
  logic              out_v_r, out_v_nxt;
  out_t              out_d_r, out_d_nxt;

  logic [NUM_KEYS-1:0] pend_vec, pick;
  logic                found;
  logic [ID_W-1:0]     pick_who;
  logic [CODE_W-1:0]   pick_code;
  logic                load;

  always_comb begin
    pick      = '0;
    found     = 1'b0;
    pick_who  = '0;
    pick_code = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      pend_vec[i] = pend[i].valid;
      if (pend[i].valid && !found) begin
        found     = 1'b1;
        pick[i]   = 1'b1;
        pick_who  = pend[i].who;
        pick_code = pend[i].code;
      end
    end
  end

  assign busy = (|pend_vec) | echo_v_r;
  assign load = busy && (!out_v_r || out_ready);
  assign grant = load ? pick : '0;

  always_comb begin
    echo_v_nxt    = echo_v_r;
    echo_who_nxt  = echo_who_r;
    echo_code_nxt = echo_code_r;
    out_v_nxt     = out_v_r;
    out_d_nxt     = out_d_r;
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (load) begin
      out_v_nxt = 1'b1;
      if (found) begin
        out_d_nxt.recipient  = pick_who;
        out_d_nxt.event_code = pick_code;
        out_d_nxt.last       = (pend_vec & ~pick) == '0;
      end else begin
        out_d_nxt.recipient  = echo_who_r;
        out_d_nxt.event_code = echo_code_r;
        out_d_nxt.last       = 1'b1;
        echo_v_nxt           = 1'b0;
      end
    end
    if (echo_in.valid) begin
      echo_v_nxt    = 1'b1;
      echo_who_nxt  = echo_in.who;
      echo_code_nxt = echo_in.code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      echo_v_r <= echo_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    echo_who_r  <= echo_who_nxt;
    echo_code_r <= echo_code_nxt;
    out_d_r     <= out_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

@@ hw/rtl/key_edge_subscription_notifier.sv @@
// Top level of the key edge subscription notifier: key lanes, merge stage, checks.
//
// Each key has its own lane holding its press and release subscriber and
// flags its notification when a sample shows an edge on a subscribed key; the
// merge stage moves one notification per cycle, lowest key first, into the
// output register whenever it is empty or being taken. A sample latches its
// edges into the lanes' pending registers; its results then move out one by
// one. A clear request is registered as an echo, then moved into the output
// register; an install only writes a slot. The next request is accepted once
// every result of the current one has reached the output register, while the
// last of them may still wait there to be taken.
`include "key_edge_subscription_notifier_defines.svh"

module key_edge_subscription_notifier
  import kesn_pkg::*;
#(
  parameter int NUM_KEYS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [NUM_KEYS-1:0] key_levels_r, key_levels_nxt;
  logic                busy;
  logic                accept;
  logic [NUM_KEYS-1:0] grant;
  kesn_note_t          pend [NUM_KEYS];
  kesn_note_t          echo_in;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    key_levels_nxt = key_levels_r;
    if (accept && !in_data.op) begin
      key_levels_nxt = in_data.levels[NUM_KEYS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_levels_r <= '0;
    end else begin
      key_levels_r <= key_levels_nxt;
    end
  end

  assign echo_in.valid = accept && in_data.op && in_data.clear_request;
  assign echo_in.who   = in_data.requester;
  assign echo_in.code  = CODE_CLEAR | (in_data.release_edge ? CODE_RELEASE : '0)
                       | {2'b00, in_data.key_index};

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
    kesn_lane_ctl_t ctl;

    assign ctl.sample_en = accept && !in_data.op;
    assign ctl.lvl_old   = key_levels_r[i];
    assign ctl.lvl_new   = in_data.levels[i];
    assign ctl.req_en    = accept && in_data.op;
    assign ctl.rel       = in_data.release_edge;
    assign ctl.clr       = in_data.clear_request;
    assign ctl.who       = in_data.requester;

    kesn_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .lane_id (KEY_W'(i)),
      .ctl     (ctl),
      .req_sel (in_data.key_index == KEY_W'(i)),
      .grant   (grant[i]),
      .note    (pend[i])
    );
  end

  kesn_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .pend      (pend),
    .echo_in   (echo_in),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .grant     (grant),
    .busy      (busy)
  );

  `KESN_ASSERT_IMPL(a_idle_last, in_ready && out_valid, out_data.last, "held result not last while idle")
  `KESN_ASSERT_NEXT(a_more_follow, out_valid && out_ready && !out_data.last, out_valid, "result missing after non-last")
  `KESN_ASSERT_IMPL(a_grant_onehot, 1'b1, $onehot0(grant), "more than one lane granted")
  `KESN_ASSERT_NEXT(a_echo_busy, accept && in_data.op && in_data.clear_request, !in_ready, "clear echo not pending")

endmodule
